// ----- design/u8d_pkg.sv -----
package u8d_pkg;

  // status codes of a result beat
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_LEAD   = 3'd1;
  localparam logic [2:0] ST_INCOMPLETE = 3'd2;
  localparam logic [2:0] ST_BAD_TRAIL  = 3'd3;
  localparam logic [2:0] ST_OVERLONG   = 3'd4;
  localparam logic [2:0] ST_BAD_CP     = 3'd5;

  localparam int CP_W  = 21;
  localparam int OUT_W = 32;

  localparam logic [CP_W-1:0] CP_MIN2     = 21'h00080;
  localparam logic [CP_W-1:0] CP_MIN3     = 21'h00800;
  localparam logic [CP_W-1:0] CP_MIN4     = 21'h10000;
  localparam logic [CP_W-1:0] CP_SURR_LO  = 21'h0D800;
  localparam logic [CP_W-1:0] CP_SURR_HI  = 21'h0DFFF;
  localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
  localparam logic [5:0]      TRAIL_MASK  = 6'h3F;
  localparam logic [7:0]      NEWLINE     = 8'h0A;

  // one result produced by the sequence assembler
  typedef struct packed {
    logic            valid;
    logic [CP_W-1:0] cp;
    logic [2:0]      len;
    logic [2:0]      status;
    logic            endf;
  } seq_res_t;

  // counter update request
  typedef struct packed {
    logic bump_off;  // offset + 1
    logic bump_pos;  // column + 1, or line + 1 and column cleared
    logic newline;
  } pos_evt_t;

endpackage

// ----- design/u8d_seq.sv -----
module u8d_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  logic [7:0]         data_byte,
  input  logic               end_of_input,
  output u8d_pkg::seq_res_t  res,
  output u8d_pkg::pos_evt_t  evt
);

  logic [1:0]                  pend_r, pend_nxt;
  logic [2:0]                  slen_r, slen_nxt;
  logic [u8d_pkg::CP_W-1:0]    acc_r, acc_nxt;
  logic                        tbad_r, tbad_nxt;
  logic [u8d_pkg::CP_W-1:0]    acc_sh;
  logic                        trail_ok;

  assign trail_ok = (data_byte[7:6] == 2'b10);
  assign acc_sh   = {acc_r[u8d_pkg::CP_W-7:0], data_byte[5:0] & u8d_pkg::TRAIL_MASK};

  always_comb begin
    pend_nxt = pend_r;
    slen_nxt = slen_r;
    acc_nxt  = acc_r;
    tbad_nxt = tbad_r;
    res      = '0;
    evt      = '0;
    if (end_of_input) begin
      res.valid = 1'b1;
      res.endf  = 1'b1;
      if (pend_r != 2'd0) begin
        pend_nxt   = 2'd0;
        slen_nxt   = 3'd0;
        acc_nxt    = '0;
        tbad_nxt   = 1'b0;
        res.status = u8d_pkg::ST_INCOMPLETE;
      end else begin
        res.status   = u8d_pkg::ST_OK;
        evt.bump_off = 1'b1;
      end
    end else if (pend_r == 2'd0) begin
      priority if (data_byte[7] == 1'b0) begin
        res.valid    = 1'b1;
        res.cp       = u8d_pkg::CP_W'(data_byte);
        res.len      = 3'd1;
        res.status   = u8d_pkg::ST_OK;
        evt.bump_off = 1'b1;
        evt.bump_pos = 1'b1;
        evt.newline  = (data_byte == u8d_pkg::NEWLINE);
      end else if (data_byte[7:5] == 3'b110) begin
        slen_nxt = 3'd2;
        pend_nxt = 2'd1;
        acc_nxt  = u8d_pkg::CP_W'(data_byte[4:0]);
        tbad_nxt = 1'b0;
      end else if (data_byte[7:4] == 4'b1110) begin
        slen_nxt = 3'd3;
        pend_nxt = 2'd2;
        acc_nxt  = u8d_pkg::CP_W'(data_byte[3:0]);
        tbad_nxt = 1'b0;
      end else if (data_byte[7:3] == 5'b11110) begin
        slen_nxt = 3'd4;
        pend_nxt = 2'd3;
        acc_nxt  = u8d_pkg::CP_W'(data_byte[2:0]);
        tbad_nxt = 1'b0;
      end else begin
        res.valid  = 1'b1;
        res.status = u8d_pkg::ST_BAD_LEAD;
      end
    end else begin
      // trailing byte: a malformed one is remembered, the value kept
      tbad_nxt = tbad_r | ~trail_ok;
      acc_nxt  = trail_ok ? acc_sh : acc_r;
      pend_nxt = pend_r - 2'd1;
      if (pend_nxt == 2'd0) begin
        res.valid = 1'b1;
        res.len   = slen_r;
        priority if (tbad_nxt) begin
          res.status = u8d_pkg::ST_BAD_TRAIL;
        end else if ((slen_r == 3'd2 && acc_nxt < u8d_pkg::CP_MIN2) ||
                     (slen_r == 3'd3 && acc_nxt < u8d_pkg::CP_MIN3) ||
                     (slen_r == 3'd4 && acc_nxt < u8d_pkg::CP_MIN4)) begin
          res.status = u8d_pkg::ST_OVERLONG;
        end else if ((acc_nxt >= u8d_pkg::CP_SURR_LO && acc_nxt <= u8d_pkg::CP_SURR_HI) ||
                     acc_nxt > u8d_pkg::CP_MAX) begin
          res.status = u8d_pkg::ST_BAD_CP;
        end else begin
          res.status   = u8d_pkg::ST_OK;
          res.cp       = acc_nxt;
          evt.bump_off = 1'b1;
          evt.bump_pos = 1'b1;
        end
        slen_nxt = 3'd0;
        acc_nxt  = '0;
        tbad_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
      slen_r <= 3'd0;
      acc_r  <= '0;
      tbad_r <= 1'b0;
    end else if (fire) begin
      pend_r <= pend_nxt;
      slen_r <= slen_nxt;
      acc_r  <= acc_nxt;
      tbad_r <= tbad_nxt;
    end
  end

endmodule

// ----- design/u8d_pos.sv -----
module u8d_pos #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fire,
  input  u8d_pkg::pos_evt_t      evt,
  output logic [COUNT_WIDTH-1:0] off_nxt,
  output logic [COUNT_WIDTH-1:0] line_nxt,
  output logic [COUNT_WIDTH-1:0] col_nxt
);

  logic [COUNT_WIDTH-1:0] off_r, line_r, col_r;

  always_comb begin
    off_nxt  = off_r;
    line_nxt = line_r;
    col_nxt  = col_r;
    if (evt.bump_off) begin
      off_nxt = off_r + COUNT_WIDTH'(1);
    end
    if (evt.bump_pos) begin
      if (evt.newline) begin
        line_nxt = line_r + COUNT_WIDTH'(1);
        col_nxt  = '0;
      end else begin
        col_nxt = col_r + COUNT_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r  <= '0;
      line_r <= '0;
      col_r  <= '0;
    end else if (fire) begin
      off_r  <= off_nxt;
      line_r <= line_nxt;
      col_r  <= col_nxt;
    end
  end

endmodule

// ----- design/utf8_stream_decoder_with_position.sv -----
// Path: an accepted input beat is held in the input register, its result beat in the result register.
// Throughput: one input beat per cycle unless out_tready stalls; sequence/counter update is combinational.
// Multi-byte leads and inner trailing bytes give no result beat; every other input beat gives one.
// Reset: rst_n synchronous, active low; clears both valid flags, sequence state and all counters.
module utf8_stream_decoder_with_position #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  // input channel
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tuser,   // [0] end_of_input
  // result channel
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // [20:0] code_point, [23:21] char_length, [26:24] status,
                                   // [58:27] char_offset, [90:59] line_number,
                                   // [122:91] column_number, [127:123] zero
  output logic         out_tuser   // [0] end_flag
);

  // input register
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_eoi_r;

  // result register
  logic         out_valid_r, out_valid_nxt;
  logic [127:0] out_data_r;
  logic         out_user_r;

  logic adv;      // result register free to take a beat this cycle
  logic s1_fire;  // held beat is processed this cycle
  logic in_fire;

  u8d_pkg::seq_res_t res;
  u8d_pkg::pos_evt_t evt;
  logic [COUNT_WIDTH-1:0] off_nxt, line_nxt, col_nxt;
  logic [63:0] off_ext, line_ext, col_ext;

  assign adv       = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && adv;
  assign in_tready = !s1_valid_r || adv;
  assign in_fire   = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = adv ? (s1_fire && res.valid) : out_valid_r;

  u8d_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (s1_fire),
    .data_byte    (s1_byte_r),
    .end_of_input (s1_eoi_r),
    .res          (res),
    .evt          (evt)
  );

  u8d_pos #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_pos (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (s1_fire),
    .evt      (evt),
    .off_nxt  (off_nxt),
    .line_nxt (line_nxt),
    .col_nxt  (col_nxt)
  );

  // counters are reported as their low 32 bits, zero-extended when narrower
  assign off_ext  = 64'(off_nxt);
  assign line_ext = 64'(line_nxt);
  assign col_ext  = 64'(col_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_tdata;
      s1_eoi_r  <= in_tuser;
    end
    if (s1_fire && res.valid) begin
      out_data_r <= {5'd0,
                     col_ext[u8d_pkg::OUT_W-1:0],
                     line_ext[u8d_pkg::OUT_W-1:0],
                     off_ext[u8d_pkg::OUT_W-1:0],
                     res.status, res.len, res.cp};
      out_user_r <= res.endf;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // error results carry no code point
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[26:24] != u8d_pkg::ST_OK |-> out_tdata[20:0] == 21'd0)
    else $error("error result with non-zero code point");

  // end-of-input and bad-lead results report zero length
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser || out_tdata[26:24] == u8d_pkg::ST_BAD_LEAD)
      |-> out_tdata[23:21] == 3'd0)
    else $error("end or bad-lead result with non-zero length");

  // errors never move the counters
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && res.valid && res.status != u8d_pkg::ST_OK |-> !evt.bump_off && !evt.bump_pos)
    else $error("counters bumped on error");

  // counters only move with a result beat
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && !res.valid |-> !evt.bump_off && !evt.bump_pos)
    else $error("counters bumped without a result");

endmodule

// ----- dv/utf8_stream_decoder_with_position_test.sv -----
// Testbench for the UTF-8 stream decoder with position tracking.
//  - byte and end-of-input beats go in over the in_ stream
//  - a scoreboard predicts each result beat and checks it field by field
//  - both sides idle in short random bursts; once the sink holds off long
//    enough for the decoder to back up and drop in_tready
module utf8_stream_decoder_with_position_test;

  localparam int          ITEM_TARGET  = 1100;  // approximate number of input beats
  localparam int          QUIET_TAIL   = 150;   // last beats run with no idling
  localparam int          HOLD_AT      = 300;   // beat count at which the long hold starts
  localparam int          HOLD_CYCLES  = 64;    // length of the long sink hold
  localparam int          DRAIN_CYCLES = 10;    // settle time after the last result
  localparam int unsigned STALL_LIMIT  = 2000;  // cycles with no beat on either side

  // one predicted result beat
  typedef struct packed {
    logic [u8d_pkg::CP_W-1:0]  cp;
    logic [2:0]                len;
    logic [2:0]                st;
    logic                      endf;
    logic [u8d_pkg::OUT_W-1:0] off;
    logic [u8d_pkg::OUT_W-1:0] line;
    logic [u8d_pkg::OUT_W-1:0] col;
  } char_res_t;

  // Decoder predictor plus queue of results still owed by the block.
  class utf8_scoreboard;
    logic [1:0]                trail_left;  // trailing bytes still to come
    logic [2:0]                seq_len;
    logic [u8d_pkg::CP_W-1:0]  acc;
    bit                        trail_bad;
    logic [u8d_pkg::OUT_W-1:0] offset;
    logic [u8d_pkg::OUT_W-1:0] line;
    logic [u8d_pkg::OUT_W-1:0] column;
    char_res_t                 owed_q[$];
    int unsigned               mismatches;

    function new();
      trail_left = '0;
      seq_len    = '0;
      acc        = '0;
      trail_bad  = 1'b0;
      offset     = '0;
      line       = '0;
      column     = '0;
      mismatches = 0;
    endfunction

    function int unsigned waiting();
      return owed_q.size();
    endfunction

    function void drop_sequence();
      trail_left = '0;
      seq_len    = '0;
      acc        = '0;
      trail_bad  = 1'b0;
    endfunction

    function void bump_position(input bit is_newline);
      offset = offset + 1'b1;
      if (is_newline) begin
        line   = line + 1'b1;
        column = '0;
      end else begin
        column = column + 1'b1;
      end
    endfunction

    // Accepted input beat: advance the predicted state, queue any result.
    function void note_input(input logic [7:0] b, input logic eoi);
      char_res_t r;
      bit        produce;
      r       = '0;
      produce = 1'b0;
      if (eoi) begin
        r.endf  = 1'b1;
        produce = 1'b1;
        if (trail_left != 0) begin
          drop_sequence();
          r.st = u8d_pkg::ST_INCOMPLETE;
        end else begin
          offset = offset + 1'b1;
          r.st   = u8d_pkg::ST_OK;
        end
      end else if (trail_left == 0) begin
        if (b[7] == 1'b0) begin
          bump_position(b == u8d_pkg::NEWLINE);
          r.cp    = u8d_pkg::CP_W'(b);
          r.len   = 3'd1;
          r.st    = u8d_pkg::ST_OK;
          produce = 1'b1;
        end else if (b[7:5] == 3'b110) begin
          seq_len = 3'd2;
          acc     = u8d_pkg::CP_W'(b[4:0]);
        end else if (b[7:4] == 4'b1110) begin
          seq_len = 3'd3;
          acc     = u8d_pkg::CP_W'(b[3:0]);
        end else if (b[7:3] == 5'b11110) begin
          seq_len = 3'd4;
          acc     = u8d_pkg::CP_W'(b[2:0]);
        end else begin
          r.st    = u8d_pkg::ST_BAD_LEAD;
          produce = 1'b1;
        end
        if (seq_len != 0) begin
          trail_left = 2'(seq_len - 3'd1);
          trail_bad  = 1'b0;
        end
      end else begin
        if (b[7:6] != 2'b10) trail_bad = 1'b1;
        else acc = {acc[u8d_pkg::CP_W-7:0], b[5:0] & u8d_pkg::TRAIL_MASK};
        trail_left = trail_left - 2'd1;
        if (trail_left == 0) begin
          r.len   = seq_len;
          produce = 1'b1;
          if (trail_bad) r.st = u8d_pkg::ST_BAD_TRAIL;
          else if ((seq_len == 3'd2 && acc < u8d_pkg::CP_MIN2) ||
                   (seq_len == 3'd3 && acc < u8d_pkg::CP_MIN3) ||
                   (seq_len == 3'd4 && acc < u8d_pkg::CP_MIN4)) r.st = u8d_pkg::ST_OVERLONG;
          else if ((acc >= u8d_pkg::CP_SURR_LO && acc <= u8d_pkg::CP_SURR_HI) ||
                   acc > u8d_pkg::CP_MAX) r.st = u8d_pkg::ST_BAD_CP;
          else r.st = u8d_pkg::ST_OK;
          if (r.st == u8d_pkg::ST_OK) begin
            bump_position(1'b0);
            r.cp = acc;
          end
          drop_sequence();
        end
      end
      if (produce) begin
        r.off  = offset;
        r.line = line;
        r.col  = column;
        owed_q.push_back(r);
      end
    endfunction

    function void match_field(input string name, input logic [u8d_pkg::OUT_W-1:0] want,
                              input logic [u8d_pkg::OUT_W-1:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    // Accepted result beat: compare with the oldest owed result.
    function void check_result(input logic [127:0] d, input logic user);
      char_res_t e;
      if (owed_q.size() == 0) begin
        $error("result beat with nothing owed: tdata 0x%0h tuser %0b", d, user);
        mismatches++;
        return;
      end
      e = owed_q.pop_front();
      match_field("code_point",    u8d_pkg::OUT_W'(e.cp),   u8d_pkg::OUT_W'(d[20:0]));
      match_field("char_length",   u8d_pkg::OUT_W'(e.len),  u8d_pkg::OUT_W'(d[23:21]));
      match_field("status",        u8d_pkg::OUT_W'(e.st),   u8d_pkg::OUT_W'(d[26:24]));
      match_field("char_offset",   e.off,                   d[58:27]);
      match_field("line_number",   e.line,                  d[90:59]);
      match_field("column_number", e.col,                   d[122:91]);
      match_field("tdata_padding", '0,                      u8d_pkg::OUT_W'(d[127:123]));
      match_field("end_flag",      u8d_pkg::OUT_W'(e.endf), u8d_pkg::OUT_W'(user));
    endfunction
  endclass

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata   = 8'h00;  // [7:0] data_byte
  logic         in_tuser   = 1'b0;   // [0] end_of_input
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;           // [20:0] code_point, [23:21] char_length, [26:24] status,
                                     // [58:27] char_offset, [90:59] line_number,
                                     // [122:91] column_number, [127:123] zero
  logic         out_tuser;           // [0] end_flag

  utf8_scoreboard sb = new();
  int unsigned    beats_sent = 0;
  bit             quiet      = 1'b0;  // no idling on either side
  bit             hold_now   = 1'b0;  // asks the sink for one long hold

  utf8_stream_decoder_with_position #(.COUNT_WIDTH(32)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Handshakes are sampled mid-cycle: inputs and registered outputs only move
  // at the rising edge, so what is seen here is what the next edge accepts.
  // Results are checked before the input of the same cycle is noted; that
  // input's result cannot already be on the output.
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
      if (in_tvalid && in_tready) sb.note_input(in_tdata, in_tuser);
    end
  end

  // Ends the run if neither side moves a beat for too long.
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(negedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Sink: ready in runs, short random stalls, and one long hold on request.
  initial begin : sink
    wait (rst_n);
    forever begin
      if (hold_now) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_now = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Offers one beat, optionally after a short gap, and returns at the edge
  // that accepts it. tvalid is only lowered for a gap, so it never gets two
  // assignments in one step.
  task automatic send_beat(input logic [7:0] b, input logic eoi);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= eoi;
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    beats_sent++;
  endtask

  // One random run: mostly a well-formed character with random content, the
  // rest overlong forms, surrogates, values past the top of the code space,
  // broken trailing bytes, sequences cut short by end of input, stray bytes
  // and bare end markers.
  task automatic send_random_run();
    int unsigned pick;
    int unsigned n;
    int unsigned cut;
    int unsigned k;
    logic [u8d_pkg::CP_W-1:0] cp;
    logic [7:0]               seq_bytes [4];
    logic [7:0]               junk;
    pick = $urandom_range(0, 99);
    n    = $urandom_range(1, 4);
    case (n)
      1:       cp = ($urandom_range(0, 4) == 0) ? u8d_pkg::CP_W'(u8d_pkg::NEWLINE)
                                                : u8d_pkg::CP_W'($urandom_range(0, 'h7F));
      2:       cp = u8d_pkg::CP_W'($urandom_range('h80, 'h7FF));
      3:       cp = u8d_pkg::CP_W'($urandom_range('h800, 'hFFFF));
      default: cp = u8d_pkg::CP_W'($urandom_range('h10000, 'h10FFFF));
    endcase
    if (pick >= 70 && pick < 76) begin
      // overlong: value fits a shorter form
      n = $urandom_range(2, 4);
      if (n == 2) cp = u8d_pkg::CP_W'($urandom_range(0, 'h7F));
      else if (n == 3) cp = u8d_pkg::CP_W'($urandom_range(0, 'h7FF));
      else cp = u8d_pkg::CP_W'($urandom_range(0, 'hFFFF));
    end else if (pick >= 76 && pick < 81) begin
      if ($urandom_range(0, 1) == 0) begin
        n  = 3;
        cp = u8d_pkg::CP_W'($urandom_range(u8d_pkg::CP_SURR_LO, u8d_pkg::CP_SURR_HI));
      end else begin
        n  = 4;
        cp = u8d_pkg::CP_W'($urandom_range(u8d_pkg::CP_MAX + 1, 'h1FFFFF));
      end
    end

    case (n)
      1:       seq_bytes[0] = cp[7:0];
      2:       seq_bytes[0] = {3'b110, cp[10:6]};
      3:       seq_bytes[0] = {4'b1110, cp[15:12]};
      default: seq_bytes[0] = {5'b11110, cp[20:18]};
    endcase
    for (k = 1; k < n; k++) seq_bytes[k] = {2'b10, 6'(cp >> (6 * (n - 1 - k)))};

    if (pick >= 81 && pick < 88 && n > 1) begin
      // one trailing byte that is not 10xxxxxx
      cut  = $urandom_range(1, n - 1);
      junk = 8'($urandom_range(0, 255));
      if (junk[7:6] == 2'b10) junk[6] = 1'b1;
      seq_bytes[cut] = junk;
    end

    if (pick >= 88 && pick < 93 && n > 1) begin
      cut = $urandom_range(1, n - 1);
      for (k = 0; k < cut; k++) send_beat(seq_bytes[k], 1'b0);
      send_beat(8'($urandom), 1'b1);
    end else if (pick >= 93 && pick < 97) begin
      send_beat(8'($urandom), 1'b0);
    end else if (pick >= 97) begin
      send_beat(8'($urandom), 1'b1);
    end else begin
      for (k = 0; k < n; k++) send_beat(seq_bytes[k], 1'b0);
    end
  endtask

  initial begin : stimulus
    // {end_of_input, data_byte}
    logic [8:0] directed [$] = '{
      9'h000, 9'h0FF, 9'h00A, 9'h080,           // NUL, bad leads, newline
      9'h0C3, 9'h0A9,                           // two-byte character
      9'h0E2, 9'h082, 9'h0AC,                   // three-byte character
      9'h0F0, 9'h09F, 9'h098, 9'h080,           // four-byte character
      9'h0C3, 9'h041,                           // bad trailing byte
      9'h0C0, 9'h080,                           // overlong NUL
      9'h0ED, 9'h0A0, 9'h080,                   // surrogate
      9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,           // beyond the code space
      9'h0E2, 9'h082, 9'h1FF,                   // end in mid-sequence
      9'h100, 9'h155                            // clean end, repeated
    };
    bit hold_done;
    hold_done = 1'b0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_beat(directed[i][7:0], directed[i][8]);

    while (beats_sent < ITEM_TARGET) begin
      if (!hold_done && beats_sent >= HOLD_AT) begin
        hold_now  = 1'b1;
        hold_done = 1'b1;
      end
      quiet = (beats_sent >= ITEM_TARGET - QUIET_TAIL);
      send_random_run();
    end
    in_tvalid <= 1'b0;

    // the watchdog catches a result that never comes
    while (sb.waiting() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.waiting() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/u8d_pkg.sv
design/u8d_seq.sv
design/u8d_pos.sv
design/utf8_stream_decoder_with_position.sv
dv/utf8_stream_decoder_with_position_test.sv
